@@ rtl/segy_pkg.sv @@
package segy_pkg;

    // File layout sizes in bytes.
    localparam int TEXT_HEADER_BYTES   = 3200;
    localparam int BINARY_HEADER_BYTES = 400;
    localparam int TRACE_HEADER_BYTES  = 240;
    localparam int MAX_SAMPLE_BYTES    = 8;

    // Bytes in the binary header that pass between the two swapped groups.
    localparam int BIN_GAP_BYTES = 240;

    // Word queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Width of the byte index inside one word.
    localparam int WIDX_W = $clog2(MAX_SAMPLE_BYTES);

    // Configuration port.
    localparam int APB_AW = 4;

    typedef enum logic [1:0] {
        REG_EXT_HEADER_COUNT  = 2'd0,
        REG_SAMPLES_PER_TRACE = 2'd1,
        REG_SAMPLE_BYTES      = 2'd2
    } reg_index_t;

    // Regions of the file, in stream order.
    typedef enum logic [2:0] {
        RG_TEXT = 3'd0,
        RG_BIN  = 3'd1,
        RG_EXT  = 3'd2,
        RG_THDR = 3'd3,
        RG_DATA = 3'd4
    } region_t;

    typedef struct packed {
        logic [15:0] ext_header_count;
        logic [15:0] samples_per_trace;
        logic [3:0]  sample_bytes;
    } cfg_t;

    // One complete word: bytes in arrival order and the byte count.
    typedef struct packed {
        logic [MAX_SAMPLE_BYTES-1:0][7:0] data;
        logic [3:0]                       count;
    } word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Word size in bytes for a word that starts at the given region offset.
    function automatic logic [3:0] word_size(region_t rg, logic [15:0] start,
                                             logic [3:0] sbytes);
        logic [3:0] size;
        size = 4'd1;
        unique case (rg)
            RG_BIN:
            begin
                if (start < 16'd12)                         size = 4'd4;
                else if (start < 16'd60)                    size = 4'd2;
                else if (start < 16'(60 + BIN_GAP_BYTES))   size = 4'd1;
                else if (start < 16'(66 + BIN_GAP_BYTES))   size = 4'd2;
                else                                        size = 4'd1;
            end
            RG_THDR:
            begin
                if (start < 16'd28)       size = 4'd4;
                else if (start < 16'd36)  size = 4'd2;
                else if (start < 16'd68)  size = 4'd4;
                else if (start < 16'd72)  size = 4'd2;
                else if (start < 16'd88)  size = 4'd4;
                else if (start < 16'd180) size = 4'd2;
                else if (start < 16'd200) size = 4'd4;
                else if (start < 16'd204) size = 4'd2;
                else if (start < 16'd208) size = 4'd4;
                else if (start < 16'd218) size = 4'd2;
                else if (start < 16'd222) size = 4'd4;
                else if (start < 16'd224) size = 4'd2;
                else if (start < 16'd228) size = 4'd4;
                else if (start < 16'd232) size = 4'd2;
                else                      size = 4'd1;
            end
            RG_DATA:
            begin
                if (sbytes == 4'd0)                          size = 4'd1;
                else if (sbytes > 4'(MAX_SAMPLE_BYTES))      size = 4'(MAX_SAMPLE_BYTES);
                else                                         size = sbytes;
            end
            default:
            begin
                size = 4'd1;
            end
        endcase
        return size;
    endfunction

endpackage

@@ rtl/segy_endian_swapper_unit.sv @@
// Channel   Direction  Fields
// s_*       in         tdata[7:0] byte_in
// m_*       out        tdata[7:0] byte_out, tlast run_last
// APB       in/out     ext_header_count @0x0, samples_per_trace @0x4, sample_bytes @0x8
//
// One input byte is taken per cycle while the queue is not full; one output byte
// is sent per cycle while m_tready is high and words are queued. A word leaves once it is
// in the queue and loaded into the serializer; the output serializer sets the one byte per cycle rate.
// A four-word queue separates the byte classifier from the serializer, so
// s_tready drops only when that queue is full. No clearing pass after reset.
module segy_endian_swapper_unit
    import segy_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] byte_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] byte_out
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg_reg, cfg_next;
    reg_index_t reg_idx;
    logic       cfg_wr;
    logic       push;
    logic       pop;
    word_t      push_word;
    word_t      head;
    fifo_stat_t stat;

    // Register decode for the configuration port.
    always_comb
    begin
        pready   = 1'b1;
        reg_idx  = reg_index_t'(paddr[3:2]);
        cfg_wr   = psel && penable && pwrite;
        cfg_next = cfg_reg;
        prdata   = 32'd0;
        unique case (reg_idx)
            REG_EXT_HEADER_COUNT:
            begin
                prdata = {16'd0, cfg_reg.ext_header_count};
                if (cfg_wr) cfg_next.ext_header_count = pwdata[15:0];
            end
            REG_SAMPLES_PER_TRACE:
            begin
                prdata = {16'd0, cfg_reg.samples_per_trace};
                if (cfg_wr) cfg_next.samples_per_trace = pwdata[15:0];
            end
            REG_SAMPLE_BYTES:
            begin
                prdata = {28'd0, cfg_reg.sample_bytes};
                if (cfg_wr) cfg_next.sample_bytes = pwdata[3:0];
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ext_header_count  <= 16'd0;
            cfg_reg.samples_per_trace <= 16'd1;
            cfg_reg.sample_bytes      <= 4'd4;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Byte classifier and word assembly.
    segy_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .byte_in   (s_tdata),
        .cfg       (cfg_reg),
        .stat      (stat),
        .push      (push),
        .push_word (push_word)
    );

    // Queue of completed words.
    segy_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    // Reversed byte serializer.
    segy_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .byte_out  (m_tdata),
        .run_last  (m_tlast)
    );

    // A completed word never arrives at a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
        else $error("word pushed into full queue");

    // The serializer never pulls from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
        else $error("word popped from empty queue");

    // With nothing queued and nothing sent, the output stays idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.empty && !m_tvalid && !push) |=> !m_tvalid)
        else $error("output valid without a queued word");

endmodule

@@ rtl/segy_front.sv @@
module segy_front
    import segy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  cfg_t       cfg,
    input  fifo_stat_t stat,
    output logic       push,
    output word_t      push_word
);

    region_t                          region_reg, region_next;
    logic [15:0]                      offset_reg, offset_next;
    logic [15:0]                      ext_rem_reg, ext_rem_next;
    logic [15:0]                      sample_cnt_reg, sample_cnt_next;
    logic [3:0]                       fill_reg, fill_next;
    logic [MAX_SAMPLE_BYTES-1:0][7:0] buf_reg, buf_next;

    logic                             accept;
    logic                             complete;
    logic [15:0]                      start;
    logic [15:0]                      off_inc;
    logic [15:0]                      ext_dec;
    logic [15:0]                      sc_inc;
    logic [3:0]                       size;
    logic [3:0]                       fill_inc;
    logic [MAX_SAMPLE_BYTES-1:0][7:0] word_data;

    // Classify the incoming byte and track the file position.
    always_comb
    begin
        in_ready  = !stat.full;
        accept    = in_valid && !stat.full;
        start     = offset_reg - {12'd0, fill_reg};
        size      = word_size(region_reg, start, cfg.sample_bytes);
        fill_inc  = fill_reg + 4'd1;
        off_inc   = offset_reg + 16'd1;
        ext_dec   = ext_rem_reg - 16'd1;
        sc_inc    = sample_cnt_reg + 16'd1;
        word_data = buf_reg;
        word_data[fill_reg[WIDX_W-1:0]] = byte_in;
        complete  = fill_inc >= size;

        region_next     = region_reg;
        offset_next     = offset_reg;
        ext_rem_next    = ext_rem_reg;
        sample_cnt_next = sample_cnt_reg;
        fill_next       = fill_reg;
        buf_next        = buf_reg;

        if (accept)
        begin
            buf_next    = word_data;
            offset_next = off_inc;
            if (!complete)
            begin
                fill_next = fill_inc;
            end
            else
            begin
                fill_next = 4'd0;
                unique case (region_reg)
                    RG_TEXT:
                    begin
                        if (off_inc >= 16'(TEXT_HEADER_BYTES))
                        begin
                            region_next = RG_BIN;
                            offset_next = 16'd0;
                        end
                    end
                    RG_BIN:
                    begin
                        if (off_inc >= 16'(BINARY_HEADER_BYTES))
                        begin
                            ext_rem_next = cfg.ext_header_count;
                            region_next  = (cfg.ext_header_count != 16'd0) ? RG_EXT : RG_THDR;
                            offset_next  = 16'd0;
                        end
                    end
                    RG_EXT:
                    begin
                        if (off_inc >= 16'(TEXT_HEADER_BYTES))
                        begin
                            ext_rem_next = ext_dec;
                            region_next  = (ext_dec != 16'd0) ? RG_EXT : RG_THDR;
                            offset_next  = 16'd0;
                        end
                    end
                    RG_THDR:
                    begin
                        if (off_inc >= 16'(TRACE_HEADER_BYTES))
                        begin
                            sample_cnt_next = 16'd0;
                            region_next = (cfg.samples_per_trace != 16'd0) ? RG_DATA : RG_THDR;
                            offset_next = 16'd0;
                        end
                    end
                    RG_DATA:
                    begin
                        offset_next     = 16'd0;
                        sample_cnt_next = sc_inc;
                        if (sc_inc >= cfg.samples_per_trace)
                        begin
                            region_next = RG_THDR;
                        end
                    end
                    default:
                    begin
                        region_next = RG_TEXT;
                        offset_next = 16'd0;
                    end
                endcase
            end
        end

        push            = accept && complete;
        push_word.data  = word_data;
        push_word.count = fill_inc;
    end

    // Position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg     <= RG_TEXT;
            offset_reg     <= 16'd0;
            ext_rem_reg    <= 16'd0;
            sample_cnt_reg <= 16'd0;
            fill_reg       <= 4'd0;
        end
        else
        begin
            region_reg     <= region_next;
            offset_reg     <= offset_next;
            ext_rem_reg    <= ext_rem_next;
            sample_cnt_reg <= sample_cnt_next;
            fill_reg       <= fill_next;
        end
    end

    // Bytes of the word being collected.
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

@@ rtl/segy_fifo.sv @@
module segy_fifo
    import segy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  word_t      push_word,
    input  logic       pop,
    output word_t      head,
    output fifo_stat_t stat
);

    word_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    // Pointer and occupancy update.
    always_comb
    begin
        stat.full   = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
        stat.empty  = count_reg == '0;
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ rtl/segy_back.sv @@
module segy_back
    import segy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  word_t      head,
    input  fifo_stat_t stat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic       run_last
);

    word_t             cur_reg, cur_next;
    logic [WIDX_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic              take;
    logic              drain;

    // Emit the held word from its newest byte down to its oldest.
    always_comb
    begin
        out_valid  = valid_reg;
        byte_out   = cur_reg.data[idx_reg];
        run_last   = idx_reg == '0;
        take       = valid_reg && out_ready;
        drain      = !valid_reg || (take && run_last);
        pop        = drain && !stat.empty;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (take && !run_last)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (drain)
        begin
            valid_next = !stat.empty;
            if (!stat.empty)
            begin
                cur_next = head;
                idx_next = WIDX_W'(head.count - 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Word being sent.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule
